/* sv/assert_macros.svh */
// Assertion macros used by the port-level checker module of this project.
// Needs no other file; the user supplies clock, reset and the property.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define OTT_ASSERT(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error(msg);

// Concurrent assertion that also holds across reset.
`define OTT_ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) \
    else $error(msg);

`endif

/* sv/ott_pkg.sv */
// Package for the one-shot timer table: command and status codes,
// transaction structs and the default table size. No dependencies.
`default_nettype none

package ott_pkg;

  localparam int NUM_TIMERS_DEF = 10;
  localparam int DEADLINE_W     = 32;
  localparam int TAG_W          = 16;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_CREATE = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADARG = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [DEADLINE_W-1:0] timeout;
    logic [TAG_W-1:0]      tag;
    logic [3:0]            slot;
  } item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [3:0]            slot_taken;
    logic                  fired;
    logic [3:0]            fired_slot;
    logic [TAG_W-1:0]      fired_tag;
    logic [DEADLINE_W-1:0] tick_now;
  } result_t;

  // One stored timer: its tag and its absolute deadline.
  typedef struct packed {
    logic [TAG_W-1:0]      tag;
    logic [DEADLINE_W-1:0] deadline;
  } entry_t;

endpackage

`default_nettype wire

/* sv/oneshot_timer_table.sv */
// One-shot timer table: a 32-bit tick counter and NUM_TIMERS timers, built
// around one shared adder/comparator and the ott_ram entry store; uses ott_pkg.
//
// A transaction is accepted when start is high and busy is low; its single
// result appears on result for exactly one cycle with done high and cannot be
// held off, so the receiver must take it then. Delete, rejected create and
// unknown commands answer in the cycle after acceptance and never raise busy.
// A create walks the used bits one slot per cycle and stays busy until it
// finds the lowest free slot or has tried every slot (the table is full).
// A tick reads the entry RAM one slot per cycle through its registered read
// port and compares each deadline in the shared unit; it stays busy until a
// due timer fires or every slot is compared. The result follows the
// last busy cycle. Entries need no clearing after reset.
`default_nettype none

module oneshot_timer_table #(
  parameter int NUM_TIMERS = ott_pkg::NUM_TIMERS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  ott_pkg::item_t   item,
  output logic             busy,
  output logic             done,
  output ott_pkg::result_t result
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int DW = ott_pkg::DEADLINE_W;
  localparam int EW = $bits(ott_pkg::entry_t);
  localparam logic [IW-1:0] LAST = IW'(NUM_TIMERS - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CREATE = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;

  logic [1:0]                    state;
  logic [DW-1:0]                 tick_count;
  logic [NUM_TIMERS-1:0]         used;
  logic [IW-1:0]                 cnt;
  logic [IW-1:0]                 cmp_idx;
  logic                          cmp_valid;
  logic [DW-1:0]                 timeout_r;
  logic [ott_pkg::TAG_W-1:0]     tag_r;

  logic [DW-1:0]                 alu_b;
  logic                          alu_cin;
  logic [DW:0]                   alu_sum;
  logic [NUM_TIMERS-1:0]         del_mask;
  logic                          ram_we;
  ott_pkg::entry_t               wr_entry;
  logic [EW-1:0]                 rd_word;
  ott_pkg::entry_t               rd_entry;
  logic                          hit;
  logic                          done_next;

  assign busy = (state != S_IDLE);

  // Shared unit: increments the counter on an accepted tick, forms the
  // deadline for a create, and tests deadline <= tick by subtraction (the
  // carry out is set when no borrow occurs) during the scan.
  always_comb begin
    alu_b   = '0;
    alu_cin = 1'b0;
    unique case (state)
      S_IDLE: begin
        alu_cin = 1'b1;
      end
      S_CREATE: begin
        alu_b = timeout_r;
      end
      S_SCAN: begin
        alu_b   = ~rd_entry.deadline;
        alu_cin = 1'b1;
      end
      default: begin
        alu_b   = '0;
        alu_cin = 1'b0;
      end
    endcase
  end

  assign alu_sum = {1'b0, tick_count} + {1'b0, alu_b} + {{DW{1'b0}}, alu_cin};

  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      del_mask[i] = ({28'd0, item.slot} == 32'(i));
    end
  end

  assign ram_we            = (state == S_CREATE) && !used[cnt];
  assign wr_entry.tag      = tag_r;
  assign wr_entry.deadline = alu_sum[DW-1:0];
  assign rd_entry          = ott_pkg::entry_t'(rd_word);

  ott_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_TIMERS)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt),
    .wdata(wr_entry),
    .raddr(cnt),
    .rdata(rd_word)
  );

  assign hit = cmp_valid && used[cmp_idx] && alu_sum[DW];

  // A result is due whenever a transaction finishes in this cycle.
  always_comb begin
    done_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        done_next = start && (item.cmd != ott_pkg::CMD_TICK) &&
                    !(item.cmd == ott_pkg::CMD_CREATE && item.tag != '0 &&
                      item.timeout != '0);
      end
      S_CREATE: begin
        done_next = !used[cnt] || (cnt == LAST);
      end
      S_SCAN: begin
        done_next = hit || (cmp_valid && cmp_idx == LAST);
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick_count <= '0;
      used       <= '0;
      done       <= 1'b0;
      cmp_valid  <= 1'b0;
    end else begin
      done <= done_next;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            timeout_r <= item.timeout;
            tag_r     <= item.tag;
            cnt       <= '0;
            cmp_valid <= 1'b0;
            unique case (item.cmd)
              ott_pkg::CMD_TICK: begin
                tick_count <= alu_sum[DW-1:0];
                state      <= S_SCAN;
              end
              ott_pkg::CMD_CREATE: begin
                if (item.tag == '0 || item.timeout == '0) begin
                  result <= '{status: ott_pkg::ST_BADARG, slot_taken: '0, fired: 1'b0,
                              fired_slot: '0, fired_tag: '0, tick_now: tick_count};
                end else begin
                  state <= S_CREATE;
                end
              end
              ott_pkg::CMD_DELETE: begin
                used   <= used & ~del_mask;
                result <= '{status: ott_pkg::ST_OK, slot_taken: '0, fired: 1'b0,
                            fired_slot: '0, fired_tag: '0, tick_now: tick_count};
              end
              default: begin
                result <= '{status: ott_pkg::ST_BADARG, slot_taken: '0, fired: 1'b0,
                            fired_slot: '0, fired_tag: '0, tick_now: tick_count};
              end
            endcase
          end
        end
        S_CREATE: begin
          if (!used[cnt]) begin
            used[cnt] <= 1'b1;
            state     <= S_IDLE;
            result    <= '{status: ott_pkg::ST_OK, slot_taken: 4'(cnt), fired: 1'b0,
                           fired_slot: '0, fired_tag: '0, tick_now: tick_count};
          end else if (cnt == LAST) begin
            state  <= S_IDLE;
            result <= '{status: ott_pkg::ST_FULL, slot_taken: '0, fired: 1'b0,
                        fired_slot: '0, fired_tag: '0, tick_now: tick_count};
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SCAN: begin
          // The entry compared now was addressed in the previous cycle.
          if (hit) begin
            used[cmp_idx] <= 1'b0;
            state         <= S_IDLE;
            result        <= '{status: ott_pkg::ST_OK, slot_taken: '0, fired: 1'b1,
                               fired_slot: 4'(cmp_idx), fired_tag: rd_entry.tag,
                               tick_now: tick_count};
          end else if (cmp_valid && cmp_idx == LAST) begin
            state  <= S_IDLE;
            result <= '{status: ott_pkg::ST_OK, slot_taken: '0, fired: 1'b0,
                        fired_slot: '0, fired_tag: '0, tick_now: tick_count};
          end else begin
            cmp_idx   <= cnt;
            cmp_valid <= 1'b1;
            if (cnt != LAST) begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/ott_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module ott_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/ott_checker.sv */
// Port-level checker for the one-shot timer table, bound to its top level.
// Depends on ott_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ott_props (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input ott_pkg::result_t result
);

  logic fire_fields_ok;

  assign fire_fields_ok = (result.status == ott_pkg::ST_OK) && (result.slot_taken == 4'd0);

  // Every accepted transaction either raises busy or answers at once.
  `OTT_ASSERT(a_accept_answered, clk, rst, start && !busy |=> busy || done, "transaction dropped")

  // A result is only presented once the block is free again.
  `OTT_ASSERT(a_done_idle, clk, rst, done |-> !busy, "result shown while busy")

  // Leaving busy always delivers the result in that cycle.
  `OTT_ASSERT(a_busy_ends_done, clk, rst, $fell(busy) && !$past(rst) |-> done, "result missing")

  // A fired timer is reported only with an ok status and no slot taken.
  `OTT_ASSERT(a_fire_ok, clk, rst, done && result.fired |-> fire_fields_ok, "bad fire report")

  // Reset leaves no result pending and the block free.
  `OTT_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !done && !busy, "activity after reset")

endmodule

bind oneshot_timer_table ott_props u_ott_props (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);

`default_nettype wire

/* dv/ott_checker.sv */
// Checker for the one-shot timer table: keeps its own copy of the table,
// predicts one result per accepted command and compares it with the DUT output.
// Depends on ott_pkg.
`default_nettype none

module ott_checker #(
  parameter int NUM_TIMERS = ott_pkg::NUM_TIMERS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  ott_pkg::item_t   item,
  input  logic             done,
  input  ott_pkg::result_t result,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [ott_pkg::DEADLINE_W-1:0] tick_count;
  logic                           slot_used     [NUM_TIMERS];
  logic [ott_pkg::DEADLINE_W-1:0] slot_deadline [NUM_TIMERS];
  logic [ott_pkg::TAG_W-1:0]      slot_tag      [NUM_TIMERS];

  ott_pkg::result_t answer_q[$];

  // Applies one command to the shadow table and returns the answer it gives.
  function automatic ott_pkg::result_t apply_command(ott_pkg::item_t it);
    ott_pkg::result_t ans;
    bit               hit;
    ans = '0;
    hit = 1'b0;
    ans.status = ott_pkg::ST_OK;
    case (it.cmd)
      ott_pkg::CMD_TICK: begin
        tick_count = tick_count + 1;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (!hit && slot_used[i] && tick_count >= slot_deadline[i]) begin
            hit = 1'b1;
            ans.fired = 1'b1;
            ans.fired_slot = 4'(i);
            ans.fired_tag = slot_tag[i];
            slot_used[i] = 1'b0;
          end
        end
      end
      ott_pkg::CMD_CREATE: begin
        if (it.tag == '0 || it.timeout == '0) begin
          ans.status = ott_pkg::ST_BADARG;
        end else begin
          ans.status = ott_pkg::ST_FULL;
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (!hit && !slot_used[i]) begin
              hit = 1'b1;
              slot_used[i] = 1'b1;
              slot_deadline[i] = tick_count + it.timeout;
              slot_tag[i] = it.tag;
              ans.status = ott_pkg::ST_OK;
              ans.slot_taken = 4'(i);
            end
          end
        end
      end
      ott_pkg::CMD_DELETE: begin
        if (int'(it.slot) < NUM_TIMERS) begin
          slot_used[it.slot] = 1'b0;
        end
      end
      default: begin
        ans.status = ott_pkg::ST_BADARG;
      end
    endcase
    ans.tick_now = tick_count;
    return ans;
  endfunction

  function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    ott_pkg::result_t want;
    int               bad;
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        slot_used[i] = 1'b0;
        slot_deadline[i] = '0;
        slot_tag[i] = '0;
      end
      tick_count = '0;
      answer_q.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      // The answer to an earlier transaction is checked before a new one is queued.
      if (done === 1'b1) begin
        if (answer_q.size() == 0) begin
          $error("result with no command outstanding: 0x%0h", result);
          errors <= errors + 1;
        end else begin
          want = answer_q.pop_front();
          bad = 0;
          bad += field_differs("status", 32'(want.status), 32'(result.status));
          bad += field_differs("slot_taken", 32'(want.slot_taken), 32'(result.slot_taken));
          bad += field_differs("fired", 32'(want.fired), 32'(result.fired));
          bad += field_differs("fired_slot", 32'(want.fired_slot), 32'(result.fired_slot));
          bad += field_differs("fired_tag", 32'(want.fired_tag), 32'(result.fired_tag));
          bad += field_differs("tick_now", want.tick_now, result.tick_now);
          if (bad != 0) errors <= errors + 1;
        end
      end else if (done !== 1'b0) begin
        $error("done is unknown");
        errors <= errors + 1;
      end
      if (start && busy === 1'b0) begin
        answer_q.push_back(apply_command(item));
      end
      pending <= answer_q.size();
    end
  end

endmodule

`default_nettype wire

/* dv/tb_oneshot_timer_table.sv */
// Testbench top for the one-shot timer table: drives directed and random
// commands with random gaps and reports the verdict. Depends on ott_pkg,
// ott_checker and oneshot_timer_table.
`default_nettype none

module tb_oneshot_timer_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 900;
  localparam int DRAIN_LIMIT = 2000;
  // The command code that the block does not define.
  localparam logic [1:0] CMD_UNDEFINED = 2'd3;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  ott_pkg::item_t   item = '0;
  logic             busy;
  logic             done;
  ott_pkg::result_t result;
  int               errors;
  int               pending;
  bit               burst_mode = 1'b0;

  always #5 clk = ~clk;

  oneshot_timer_table dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  ott_checker chk (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue(ott_pkg::item_t it);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    item = it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);
  endtask

  function automatic ott_pkg::item_t make_item(logic [1:0] cmd, logic [31:0] timeout,
                                               logic [15:0] tag, logic [3:0] slot);
    ott_pkg::item_t it;
    it.cmd = cmd;
    it.timeout = timeout;
    it.tag = tag;
    it.slot = slot;
    return it;
  endfunction

  function automatic ott_pkg::item_t random_item();
    ott_pkg::item_t it;
    int             pick;
    it = ott_pkg::item_t'({$urandom(), $urandom()});
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.cmd = ott_pkg::CMD_TICK;
    end else if (pick < 75) begin
      it.cmd = ott_pkg::CMD_CREATE;
      it.tag = 16'($urandom_range(1, 65535));
      case ($urandom_range(0, 9))
        0: it.timeout = '0;
        1: it.tag = '0;
        2: it.timeout = $urandom() | 32'h1;
        default: it.timeout = 32'($urandom_range(1, 24));
      endcase
    end else if (pick < 95) begin
      it.cmd = ott_pkg::CMD_DELETE;
      it.slot = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(0, 9));
    end else begin
      it.cmd = CMD_UNDEFINED;
    end
    return it;
  endfunction

  initial begin
    #2ms;
    $display("tb_oneshot_timer_table failed");
    $finish;
  end

  initial begin
    bit stuck;
    stuck = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed: rejections, deadline wrap, several due timers, full table,
    // deletes of free and out-of-range slots, and the undefined command.
    issue(make_item(ott_pkg::CMD_TICK, 32'hFFFF_FFFF, 16'hFFFF, 4'hF));
    issue(make_item(ott_pkg::CMD_CREATE, 32'd5, 16'h0000, 4'h0));
    issue(make_item(ott_pkg::CMD_CREATE, 32'd0, 16'h0001, 4'h0));
    issue(make_item(ott_pkg::CMD_CREATE, 32'd0, 16'h0000, 4'h0));
    issue(make_item(ott_pkg::CMD_CREATE, 32'd1, 16'hFFFF, 4'h0));
    // Deadline wraps past zero, so this timer is due on the next tick.
    issue(make_item(ott_pkg::CMD_CREATE, 32'hFFFF_FFFF, 16'h1234, 4'h0));
    issue(make_item(ott_pkg::CMD_TICK, 32'd0, 16'd0, 4'h0));
    issue(make_item(ott_pkg::CMD_TICK, 32'd0, 16'd0, 4'h0));
    issue(make_item(ott_pkg::CMD_DELETE, 32'd0, 16'd0, 4'hF));
    issue(make_item(ott_pkg::CMD_DELETE, 32'd0, 16'd0, 4'h3));
    issue(make_item(CMD_UNDEFINED, 32'hFFFF_FFFF, 16'hFFFF, 4'hF));
    for (int i = 0; i < 10; i++) begin
      issue(make_item(ott_pkg::CMD_CREATE, 32'd1000, 16'(i + 1), 4'h0));
    end
    issue(make_item(ott_pkg::CMD_CREATE, 32'd7, 16'h00AA, 4'h0));
    issue(make_item(ott_pkg::CMD_DELETE, 32'd0, 16'd0, 4'd9));
    issue(make_item(ott_pkg::CMD_DELETE, 32'd0, 16'd0, 4'd0));
    issue(make_item(ott_pkg::CMD_CREATE, 32'd3, 16'h8001, 4'h0));

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      issue(random_item());
    end
    start = 1'b0;

    for (int c = 0; c < DRAIN_LIMIT && pending != 0; c++) @(posedge clk);
    if (pending != 0) begin
      $error("%0d results never arrived", pending);
      stuck = 1'b1;
    end
    repeat (30) @(posedge clk);

    if (errors == 0 && !stuck) begin
      $display("tb_oneshot_timer_table passed");
    end else begin
      $display("tb_oneshot_timer_table failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* oneshot_timer_table.f */
+incdir+sv
sv/ott_pkg.sv
sv/ott_ram.sv
sv/oneshot_timer_table.sv
sv/ott_checker.sv
dv/ott_checker.sv
dv/tb_oneshot_timer_table.sv
